FILE: design/wti_pkg.sv
// Shared types, widths and codes for the waypoint trajectory interpolator.
package wti_pkg;

  localparam int MaxPoints = 16;
  localparam int IdxW = 4;
  localparam int CfgW = 5;

  localparam int DivNumW = 49;
  localparam int DivDenW = 16;
  localparam int MulHalfW = 31;
  localparam int MulOpW = 2 * MulHalfW;
  localparam int MulProdW = 2 * MulOpW;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_HOLD   = 2'd1;
  localparam logic [1:0] MODE_LINEAR = 2'd2;
  localparam logic [1:0] MODE_PVT    = 2'd3;

  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [IdxW-1:0]    point_index;
    logic [15:0]        point_time;
    logic signed [31:0] point_position;
    logic signed [31:0] point_velocity;
    logic [15:0]        query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_out;
    logic [IdxW-1:0]    segment_used;
    logic               fault;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        time_ms;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } point_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SRCH_RD, OP_RD0, OP_RD1, OP_GEOM,
    OP_W_DIV, OP_W_FIN, OP_HOLD_FIN, OP_FAULT_FIN,
    OP_LIN_MUL, OP_LIN_DIV, OP_LIN_FIN,
    OP_S_DIV, OP_S_FIN, OP_A_MUL, OP_A_FIN, OP_B_MUL, OP_B_FIN,
    OP_AU_MUL, OP_AU_FIN, OP_BS_MUL, OP_BS_FIN, OP_SU_MUL, OP_SU_FIN,
    OP_SUI_MUL, OP_SUI_FIN, OP_UP_MUL, OP_UP_FIN, OP_SP_MUL, OP_SP_FIN,
    OP_DONE
  } op_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       fault;
    logic       srch_last;
    logic       out_free;
    logic       mul_busy;
    logic       div_busy;
  } dp_status_t;

endpackage

FILE: design/wti_ifs.sv
// Valid/ready channel interfaces for input items and result items.
interface wti_in_if;
  import wti_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface wti_out_if;
  import wti_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/wti_mul.sv
// Unsigned multiplier built from four 31x31 partial products, accumulated in turn.
module wti_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wti_pkg::MulOpW-1:0]    op_a,
  input  logic [wti_pkg::MulOpW-1:0]    op_b,
  output logic                          busy,
  output logic [wti_pkg::MulProdW-1:0]  product
);
  import wti_pkg::*;

  logic [2:0]            step;
  logic [MulOpW-1:0]     a_q;
  logic [MulOpW-1:0]     b_q;
  logic [MulOpW-1:0]     pp;
  logic [MulHalfW-1:0]   half_a;
  logic [MulHalfW-1:0]   half_b;
  logic [MulProdW-1:0]   addend;

  always_comb begin
    half_a = step[1] ? a_q[MulOpW-1:MulHalfW] : a_q[MulHalfW-1:0];
    half_b = step[0] ? b_q[MulOpW-1:MulHalfW] : b_q[MulHalfW-1:0];
    case (step)
      3'd1:       addend = MulProdW'(pp);
      3'd2, 3'd3: addend = MulProdW'(pp) << MulHalfW;
      3'd4:       addend = MulProdW'(pp) << MulOpW;
      default:    addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step == 3'd4) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q     <= op_a;
      b_q     <= op_b;
      product <= '0;
    end else if (busy) begin
      pp <= half_a * half_b;
      if (step != 3'd0) begin
        product <= product + addend;
      end
    end
  end

endmodule

FILE: design/wti_div.sv
// Restoring divider, one quotient bit per cycle, rounding to nearest.
module wti_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wti_pkg::DivNumW-1:0]  num,
  input  logic [wti_pkg::DivDenW-1:0]  den,
  output logic                         busy,
  output logic [wti_pkg::DivNumW-1:0]  quot
);
  import wti_pkg::*;

  localparam int CountW = $clog2(DivNumW);
  localparam logic [CountW-1:0] CountLast = CountW'(DivNumW - 1);

  logic [CountW-1:0]  count;
  logic [DivDenW-1:0] rem;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW:0]   rem_sh;
  logic [DivDenW:0]   diff;
  logic               fits;

  always_comb begin
    rem_sh = {rem, quot[DivNumW-1]};
    diff   = rem_sh - {1'b0, den_q};
    fits   = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == CountLast) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num + DivNumW'(den >> 1);
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      rem  <= fits ? diff[DivDenW-1:0] : rem_sh[DivDenW-1:0];
      quot <= {quot[DivNumW-2:0], fits};
    end
  end

endmodule

FILE: design/wti_dp.sv
// Datapath: waypoint memory, segment search, arithmetic registers and result register.
module wti_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  wti_pkg::ctrl_cmd_t    cmd,
  output wti_pkg::dp_status_t   status,
  input  wti_pkg::in_item_t     in_item,
  output wti_pkg::out_item_t    out_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  cfg_we,
  input  logic [wti_pkg::CfgW-1:0] cfg_data
);
  import wti_pkg::*;

  localparam wide_t SatLim = 64'sh2000_0000_0000_0000;
  localparam logic [MulOpW-1:0] SatMag = MulOpW'(64'h2000_0000_0000_0000);
  localparam int RecipShift = 51;
  localparam wide_t RecipK = 64'sd2251799813686;
  localparam wide_t RoundHalf = 64'sd500;

  in_item_t             item_q;
  logic [CfgW-1:0]      num_points_q;
  logic [IdxW-1:0]      n_last;

  point_t               mem [MaxPoints];
  point_t               rdata;
  logic [IdxW-1:0]      rd_addr;
  logic                 rd_en;
  logic [IdxW-1:0]      addr_q;
  logic [IdxW-1:0]      rd_idx;
  logic [IdxW-1:0]      seg_q;
  logic                 rd_valid;
  logic [15:0]          prev_time;

  logic [15:0]          t0_q;
  logic signed [31:0]   p0_q;
  logic signed [31:0]   v0_q;
  logic signed [31:0]   p1_q;
  logic signed [31:0]   v1_q;
  logic signed [16:0]   h_q;
  logic signed [16:0]   d_q;
  logic signed [32:0]   dp_q;
  logic                 fault_q;
  logic signed [33:0]   s_q;
  logic signed [33:0]   u_q;
  logic signed [39:0]   a_q;
  logic signed [39:0]   b_q;
  wide_t                acc1_q;
  wide_t                su_q;
  wide_t                acc2_q;
  wide_t                acc3_q;
  logic signed [31:0]   pos_q;

  logic                 mul_start;
  logic                 mul_busy;
  logic                 mul_neg;
  wide_t                mul_x;
  wide_t                mul_y;
  logic [MulProdW-1:0]  mul_prod;

  logic                 div_start;
  logic                 div_busy;
  logic                 div_neg;
  logic                 div_neg_next;
  logic [DivNumW-1:0]   div_num;
  logic [DivDenW-1:0]   div_den;
  logic [DivNumW-1:0]   div_quot;

  logic [15:0]          h_mag;
  logic [15:0]          d_mag;
  logic [31:0]          v_mag;
  logic [31:0]          w_mag;
  logic signed [31:0]   vel_scaled;
  wide_t                quot_s;
  wide_t                q16_r;
  wide_t                r512;

  out_item_t            out_q;
  logic                 out_valid_q;

  function automatic logic [MulOpW-1:0] mag62(input wide_t x);
    return x[63] ? MulOpW'(-x) : MulOpW'(x);
  endfunction

  function automatic wide_t q16(input logic [MulProdW-1:0] p, input logic neg);
    logic [MulProdW-1:0] r;
    logic [MulOpW-1:0]   m;
    r = (p + MulProdW'(32768)) >> 16;
    m = (r > MulProdW'(SatMag)) ? SatMag : r[MulOpW-1:0];
    return neg ? -wide_t'({2'b0, m}) : wide_t'({2'b0, m});
  endfunction

  function automatic wide_t rnd512(input logic [63:0] p, input logic neg);
    logic [63:0] m;
    m = (p + 64'd256) >> 9;
    return neg ? -wide_t'(m) : wide_t'(m);
  endfunction

  function automatic wide_t sadd(input wide_t a, input wide_t b);
    wide_t s;
    s = a + b;
    if (s > SatLim) begin
      return SatLim;
    end else if (s < -SatLim) begin
      return -SatLim;
    end
    return s;
  endfunction

  function automatic logic signed [31:0] clamp32(input wide_t x);
    if (x > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -64'sh8000_0000) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  always_comb begin
    if (num_points_q < CfgW'(2)) begin
      n_last = IdxW'(1);
    end else if (num_points_q > CfgW'(MaxPoints)) begin
      n_last = IdxW'(MaxPoints - 1);
    end else begin
      n_last = IdxW'(num_points_q - CfgW'(1));
    end
  end

  always_comb begin
    h_mag  = 16'(h_q[16] ? -h_q : h_q);
    d_mag  = 16'(d_q[16] ? -d_q : d_q);
    v_mag  = item_q.point_velocity[31] ? 32'(-item_q.point_velocity)
                                       : 32'(item_q.point_velocity);
    w_mag  = mul_prod[RecipShift +: 32];
    vel_scaled = item_q.point_velocity[31] ? -$signed(w_mag) : $signed(w_mag);
    quot_s = div_neg ? -wide_t'({15'b0, div_quot}) : wide_t'({15'b0, div_quot});
    q16_r  = q16(mul_prod, mul_neg);
    r512   = rnd512(mul_prod[63:0], mul_neg);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = addr_q;
    case (cmd.op)
      OP_SRCH_RD: rd_en = 1'b1;
      OP_RD0: begin
        rd_en   = 1'b1;
        rd_addr = seg_q;
      end
      OP_RD1: begin
        rd_en   = 1'b1;
        rd_addr = seg_q + 1'b1;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_comb begin
    mul_start = 1'b1;
    mul_x     = '0;
    mul_y     = '0;
    case (cmd.op)
      OP_W_DIV:   begin mul_x = 64'({v_mag, 9'b0}) + RoundHalf; mul_y = RecipK; end
      OP_LIN_MUL: begin mul_x = 64'(dp_q);   mul_y = 64'(d_q);    end
      OP_A_MUL:   begin mul_x = 64'(v0_q);   mul_y = 64'(h_q);    end
      OP_B_MUL:   begin mul_x = 64'(v1_q);   mul_y = 64'(h_q);    end
      OP_AU_MUL:  begin mul_x = 64'(a_q);    mul_y = 64'(u_q);    end
      OP_BS_MUL:  begin mul_x = 64'(b_q);    mul_y = 64'(s_q);    end
      OP_SU_MUL:  begin mul_x = 64'(s_q);    mul_y = 64'(u_q);    end
      OP_SUI_MUL: begin mul_x = su_q;        mul_y = acc1_q;      end
      OP_UP_MUL:  begin mul_x = 64'(u_q);    mul_y = 64'(p0_q);   end
      OP_SP_MUL:  begin mul_x = 64'(s_q);    mul_y = 64'(p1_q);   end
      default:    mul_start = 1'b0;
    endcase
  end

  always_comb begin
    div_start    = 1'b1;
    div_num      = '0;
    div_den      = h_mag;
    div_neg_next = 1'b0;
    case (cmd.op)
      OP_LIN_DIV: begin
        div_num      = mul_prod[DivNumW-1:0];
        div_neg_next = mul_neg ^ h_q[16];
      end
      OP_S_DIV: begin
        div_num      = DivNumW'({d_mag, 16'b0});
        div_neg_next = d_q[16] ^ h_q[16];
      end
      default: div_start = 1'b0;
    endcase
  end

  wti_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_a    (mag62(mul_x)),
    .op_b    (mag62(mul_y)),
    .busy    (mul_busy),
    .product (mul_prod)
  );

  wti_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.op == OP_W_FIN) begin
      mem[item_q.point_index] <= '{time_ms:  item_q.point_time,
                                   position: item_q.point_position,
                                   velocity: vel_scaled};
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_points_q <= CfgW'(2);
      rd_valid     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_points_q <= cfg_data;
      end
      rd_valid <= (cmd.op == OP_SRCH_RD);
      if (cmd.op == OP_DONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mul_neg <= mul_x[63] ^ mul_y[63];
    end
    if (div_start) begin
      div_neg <= div_neg_next;
    end
    if (rd_valid) begin
      prev_time <= rdata.time_ms;
      if (rd_idx != '0 && prev_time <= item_q.query_time &&
          item_q.query_time < rdata.time_ms) begin
        seg_q <= rd_idx - 1'b1;
      end
    end
    case (cmd.op)
      OP_LOAD: begin
        item_q  <= in_item;
        addr_q  <= '0;
        seg_q   <= '0;
        fault_q <= 1'b0;
      end
      OP_SRCH_RD: begin
        addr_q <= addr_q + 1'b1;
        rd_idx <= addr_q;
      end
      OP_RD1: begin
        t0_q <= rdata.time_ms;
        p0_q <= rdata.position;
        v0_q <= rdata.velocity;
      end
      OP_GEOM: begin
        p1_q    <= rdata.position;
        v1_q    <= rdata.velocity;
        h_q     <= $signed({1'b0, rdata.time_ms}) - $signed({1'b0, t0_q});
        d_q     <= $signed({1'b0, item_q.query_time}) - $signed({1'b0, t0_q});
        dp_q    <= 33'(rdata.position) - 33'(p0_q);
        fault_q <= (rdata.time_ms == t0_q);
      end
      OP_W_FIN:    pos_q <= '0;
      OP_HOLD_FIN: pos_q <= p0_q;
      OP_FAULT_FIN: begin
        if (dp_q > 33'sd0) begin
          pos_q <= 32'sh7FFF_FFFF;
        end else if (dp_q < 33'sd0) begin
          pos_q <= 32'sh8000_0000;
        end else begin
          pos_q <= p0_q;
        end
      end
      OP_LIN_FIN: pos_q <= clamp32(64'(p0_q) + quot_s);
      OP_S_FIN: begin
        s_q <= 34'(quot_s);
        u_q <= 34'sd65536 - 34'(quot_s);
      end
      OP_A_FIN:   a_q <= 40'(r512 - 64'(dp_q));
      OP_B_FIN:   b_q <= 40'(64'(dp_q) - r512);
      OP_AU_FIN:  acc1_q <= q16_r;
      OP_BS_FIN:  acc1_q <= sadd(acc1_q, q16_r);
      OP_SU_FIN:  su_q <= q16_r;
      OP_SUI_FIN: acc2_q <= q16_r;
      OP_UP_FIN:  acc3_q <= q16_r;
      OP_SP_FIN:  pos_q <= clamp32(sadd(sadd(acc3_q, q16_r), acc2_q));
      OP_DONE: begin
        out_q.position_out <= pos_q;
        out_q.segment_used <= seg_q;
        out_q.fault        <= fault_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.mode      = item_q.mode;
    status.fault     = fault_q;
    status.srch_last = (addr_q == n_last);
    status.out_free  = !out_valid_q || out_ready;
    status.mul_busy  = mul_busy;
    status.div_busy  = div_busy;
    out_item         = out_q;
    out_valid        = out_valid_q;
  end

endmodule

FILE: design/wti_ctrl.sv
// Controller: sequences search, table reads and the arithmetic program of each item.
module wti_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                items_valid,
  output logic                items_ready,
  input  wti_pkg::dp_status_t status,
  output wti_pkg::ctrl_cmd_t  cmd
);
  import wti_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SEARCH, S_DRAIN, S_FETCH0, S_FETCH1,
    S_GEOM, S_SELECT, S_RUN, S_WAIT
  } state_t;

  localparam int ProgLen = 30;
  localparam int PcW = $clog2(ProgLen);
  localparam logic [PcW-1:0] PC_WRITE = PcW'(0);
  localparam logic [PcW-1:0] PC_HOLD  = PcW'(3);
  localparam logic [PcW-1:0] PC_FAULT = PcW'(5);
  localparam logic [PcW-1:0] PC_LIN   = PcW'(7);
  localparam logic [PcW-1:0] PC_PVT   = PcW'(11);

  localparam op_t Program [ProgLen] = '{
    OP_W_DIV, OP_W_FIN, OP_DONE,
    OP_HOLD_FIN, OP_DONE,
    OP_FAULT_FIN, OP_DONE,
    OP_LIN_MUL, OP_LIN_DIV, OP_LIN_FIN, OP_DONE,
    OP_S_DIV, OP_S_FIN, OP_A_MUL, OP_A_FIN, OP_B_MUL, OP_B_FIN,
    OP_AU_MUL, OP_AU_FIN, OP_BS_MUL, OP_BS_FIN, OP_SU_MUL, OP_SU_FIN,
    OP_SUI_MUL, OP_SUI_FIN, OP_UP_MUL, OP_UP_FIN, OP_SP_MUL, OP_SP_FIN,
    OP_DONE
  };

  state_t         state;
  logic [PcW-1:0] pc;
  op_t            cur_op;
  logic           accept;
  logic           unit_start;

  always_comb begin
    cur_op      = Program[pc];
    items_ready = (state == S_IDLE);
    accept      = items_valid && items_ready;
    case (cur_op) inside
      OP_W_DIV, OP_LIN_MUL, OP_LIN_DIV, OP_S_DIV, OP_A_MUL, OP_B_MUL, OP_AU_MUL,
      OP_BS_MUL, OP_SU_MUL, OP_SUI_MUL, OP_UP_MUL, OP_SP_MUL: unit_start = 1'b1;
      default: unit_start = 1'b0;
    endcase
  end

  always_comb begin
    unique case (state)
      S_IDLE:   cmd.op = accept ? OP_LOAD : OP_NONE;
      S_SEARCH: cmd.op = OP_SRCH_RD;
      S_FETCH0: cmd.op = OP_RD0;
      S_FETCH1: cmd.op = OP_RD1;
      S_GEOM:   cmd.op = OP_GEOM;
      S_RUN:    cmd.op = (cur_op == OP_DONE && !status.out_free) ? OP_NONE : cur_op;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (status.mode == MODE_WRITE) begin
            pc    <= PC_WRITE;
            state <= S_RUN;
          end else begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (status.srch_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN:  state <= S_FETCH0;
        S_FETCH0: state <= S_FETCH1;
        S_FETCH1: state <= S_GEOM;
        S_GEOM:   state <= S_SELECT;
        S_SELECT: begin
          state <= S_RUN;
          if (status.mode == MODE_HOLD) begin
            pc <= PC_HOLD;
          end else if (status.fault) begin
            pc <= PC_FAULT;
          end else if (status.mode == MODE_LINEAR) begin
            pc <= PC_LIN;
          end else begin
            pc <= PC_PVT;
          end
        end
        S_RUN: begin
          if (cur_op == OP_DONE) begin
            if (status.out_free) begin
              state <= S_IDLE;
            end
          end else if (unit_start) begin
            state <= S_WAIT;
          end else begin
            pc <= pc + 1'b1;
          end
        end
        S_WAIT: begin
          if (!status.mul_busy && !status.div_busy) begin
            pc    <= pc + 1'b1;
            state <= S_RUN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A new item is taken only when neither arithmetic unit is still working.
  assert property (@(posedge clk) disable iff (rst)
    items_ready |-> !status.mul_busy && !status.div_busy)
    else $error("item accepted while an arithmetic unit is busy");

  // A result is handed over only when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DONE |-> status.out_free)
    else $error("result loaded over an untaken result");

  // The unit started on the way into the wait state must be running.
  assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT && $past(state) == S_RUN |-> status.mul_busy || status.div_busy)
    else $error("wait entered without a running unit");

endmodule

FILE: design/waypoint_trajectory_interpolator_unit.sv
// Top level of the waypoint trajectory interpolator.
// The block handles one item at a time. For a waypoint write the velocity is scaled
// by a reciprocal multiplication on the shared multiplier. A query first scans the
// time table through its single read port over the points in use; a hold query then
// needs no arithmetic unit, a linear query uses one multiplication and one division
// and a position-velocity-time query one division and eight multiplications on the
// shared four-partial-product multiplier. A finished result waits in an output register,
// so the next item is taken while the previous result is still unread. The waypoint table
// has no reset; querying an entry that was never written gives undefined values.
module waypoint_trajectory_interpolator_unit (
  input  logic                     clk,
  input  logic                     rst,
  wti_in_if.sink                   items,
  wti_out_if.source                results,
  input  logic                     cfg_we,
  input  logic [wti_pkg::CfgW-1:0] cfg_data
);
  import wti_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  wti_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .items_valid (items.valid),
    .items_ready (items.ready),
    .status      (status),
    .cmd         (cmd)
  );

  wti_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (items.payload),
    .out_item  (results.payload),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

endmodule
